// File: design/rpbu_pkg.sv
package rpbu_pkg;

   localparam int unsigned PixelWidth = 8;
   localparam int unsigned AmountWidth = 9;
   localparam int unsigned ModeWidth = 3;
   localparam int unsigned SelectWidth = 2;
   localparam int unsigned IndexWidth = 2;
   localparam int unsigned OpxWidth = 10;
   localparam int unsigned ProductWidth = OpxWidth + AmountWidth;
   localparam int unsigned DivWidth = 17;
   localparam int unsigned QuotWidth = 9;

   localparam logic [ModeWidth-1:0] MODE_MULTIPLY = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_SCREEN = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_SUBTRACT = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_OVERLAY = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_SCALE = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_ADD = 3'd5;

   localparam logic [IndexWidth-1:0] REG_BLEND_MODE = 2'd0;
   localparam logic [IndexWidth-1:0] REG_CHANNEL_SELECT = 2'd1;
   localparam logic [IndexWidth-1:0] REG_CHANNEL_AMOUNT = 2'd2;

   localparam logic [SelectWidth-1:0] CHAN_BLUE = 2'd0;
   localparam logic [SelectWidth-1:0] CHAN_GREEN = 2'd1;
   localparam logic [SelectWidth-1:0] CHAN_RED = 2'd2;

   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_DIV = 2'd1;
   localparam logic [1:0] KIND_INV = 2'd2;
   localparam logic [1:0] KIND_CLAMP = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [OpxWidth-1:0] opx;
      logic [AmountWidth-1:0] opy;
      logic [PixelWidth-1:0] value;
   } lane_op_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// File: design/rgb_pixel_blend_unit.sv
// A word accepted into stage 1 moves on through stages 2 and 3 to stage 4, which drives rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; each stage holds a word and moves it on
// as soon as the stage after it is free, so bubbles close up under a stall on rsp_stall.
// Reset clears all valid bits and sets blend_mode 0, channel_select 0 and
// channel_amount 1.
module rgb_pixel_blend_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_top_blue,
   input logic [7:0] req_top_green,
   input logic [7:0] req_top_red,
   input logic [7:0] req_bottom_blue,
   input logic [7:0] req_bottom_green,
   input logic [7:0] req_bottom_red,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_red,
   input logic csr_write_en,
   input logic [rpbu_pkg::IndexWidth-1:0] csr_index,
   input logic [rpbu_pkg::AmountWidth-1:0] csr_write_data
);

   logic [rpbu_pkg::ModeWidth-1:0] mode_ff;
   logic [rpbu_pkg::SelectWidth-1:0] select_ff;
   logic [rpbu_pkg::AmountWidth-1:0] amount_ff;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   rpbu_pkg::stage_en_type en;

   rpbu_pkg::lane_op_type op_blue;
   rpbu_pkg::lane_op_type op_green;
   rpbu_pkg::lane_op_type op_red;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rpbu_pkg::MODE_MULTIPLY;
         select_ff <= rpbu_pkg::CHAN_BLUE;
         amount_ff <= 9'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            rpbu_pkg::REG_BLEND_MODE: mode_ff <= csr_write_data[rpbu_pkg::ModeWidth-1:0];
            rpbu_pkg::REG_CHANNEL_SELECT:
               select_ff <= csr_write_data[rpbu_pkg::SelectWidth-1:0];
            rpbu_pkg::REG_CHANNEL_AMOUNT: amount_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign en.s4 = !valid_ff[3] || !rsp_stall;
   assign en.s3 = !valid_ff[2] || en.s4;
   assign en.s2 = !valid_ff[1] || en.s3;
   assign en.s1 = !valid_ff[0] || en.s2;

   assign valid_in[0] = en.s1 ? req_valid : valid_ff[0];
   assign valid_in[1] = en.s2 ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = en.s3 ? valid_ff[1] : valid_ff[2];
   assign valid_in[3] = en.s4 ? valid_ff[2] : valid_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en.s1;
   assign rsp_valid = valid_ff[3];

   rpbu_prep u_prep_blue (
      .blend_mode(mode_ff),
      .channel_select(select_ff),
      .channel_amount(amount_ff),
      .channel_id(rpbu_pkg::CHAN_BLUE),
      .top(req_top_blue),
      .bottom(req_bottom_blue),
      .op(op_blue)
   );

   rpbu_prep u_prep_green (
      .blend_mode(mode_ff),
      .channel_select(select_ff),
      .channel_amount(amount_ff),
      .channel_id(rpbu_pkg::CHAN_GREEN),
      .top(req_top_green),
      .bottom(req_bottom_green),
      .op(op_green)
   );

   rpbu_prep u_prep_red (
      .blend_mode(mode_ff),
      .channel_select(select_ff),
      .channel_amount(amount_ff),
      .channel_id(rpbu_pkg::CHAN_RED),
      .top(req_top_red),
      .bottom(req_bottom_red),
      .op(op_red)
   );

   rpbu_lane u_lane_blue (
      .clock(clock),
      .en(en),
      .op(op_blue),
      .result(rsp_out_blue)
   );

   rpbu_lane u_lane_green (
      .clock(clock),
      .en(en),
      .op(op_green),
      .result(rsp_out_green)
   );

   rpbu_lane u_lane_red (
      .clock(clock),
      .en(en),
      .op(op_red),
      .result(rsp_out_red)
   );

endmodule

// File: design/rpbu_prep.sv
module rpbu_prep (
   input logic [rpbu_pkg::ModeWidth-1:0] blend_mode,
   input logic [rpbu_pkg::SelectWidth-1:0] channel_select,
   input logic [rpbu_pkg::AmountWidth-1:0] channel_amount,
   input logic [rpbu_pkg::SelectWidth-1:0] channel_id,
   input logic [rpbu_pkg::PixelWidth-1:0] top,
   input logic [rpbu_pkg::PixelWidth-1:0] bottom,
   output rpbu_pkg::lane_op_type op
);

   logic hit;
   logic signed [10:0] sum;
   logic [7:0] add_value;
   logic [7:0] sub_value;

   assign hit = (channel_select == channel_id);
   assign sum = $signed({3'b000, top}) +
                $signed({{2{channel_amount[8]}}, channel_amount});
   assign sub_value = (top > bottom) ? (top - bottom) : 8'd0;

   always_comb begin
      if (sum[10]) begin
         add_value = 8'd0;
      end else if (sum[9:8] != 2'b00) begin
         add_value = 8'hFF;
      end else begin
         add_value = sum[7:0];
      end
   end

   always_comb begin
      op.kind = rpbu_pkg::KIND_PASS;
      op.opx = '0;
      op.opy = '0;
      op.value = top;
      case (blend_mode)
         rpbu_pkg::MODE_MULTIPLY: begin
            op.kind = rpbu_pkg::KIND_DIV;
            op.opx = {2'b00, top};
            op.opy = {1'b0, bottom};
         end
         rpbu_pkg::MODE_SCREEN: begin
            op.kind = rpbu_pkg::KIND_INV;
            op.opx = {2'b00, ~top};
            op.opy = {1'b0, ~bottom};
         end
         rpbu_pkg::MODE_SUBTRACT: begin
            op.value = sub_value;
         end
         rpbu_pkg::MODE_OVERLAY: begin
            if (bottom[7]) begin
               op.kind = rpbu_pkg::KIND_INV;
               op.opx = {1'b0, ~top, 1'b0};
               op.opy = {1'b0, ~bottom};
            end else begin
               op.kind = rpbu_pkg::KIND_DIV;
               op.opx = {1'b0, top, 1'b0};
               op.opy = {1'b0, bottom};
            end
         end
         rpbu_pkg::MODE_SCALE: begin
            if (hit) begin
               op.kind = rpbu_pkg::KIND_CLAMP;
               op.opx = {2'b00, top};
               op.opy = channel_amount;
            end
         end
         rpbu_pkg::MODE_ADD: begin
            if (hit) begin
               op.value = add_value;
            end
         end
         default: begin
            op.value = top;
         end
      endcase
   end

endmodule

// File: design/rpbu_lane.sv
module rpbu_lane (
   input logic clock,
   input rpbu_pkg::stage_en_type en,
   input rpbu_pkg::lane_op_type op,
   output logic [rpbu_pkg::PixelWidth-1:0] result
);

   // Stage 1 holds operands, stage 2 the product, stage 3 the quotient
   // estimate, stage 4 the corrected result.
   rpbu_pkg::lane_op_type op_ff;

   logic [1:0] kind2_ff;
   logic [7:0] value2_ff;
   logic signed [rpbu_pkg::ProductWidth-1:0] prod_in;
   logic signed [rpbu_pkg::ProductWidth-1:0] prod_ff;

   logic [1:0] kind3_ff;
   logic [7:0] value3_ff;
   logic [7:0] value3_in;
   logic [rpbu_pkg::DivWidth-1:0] num_in;
   logic [rpbu_pkg::DivWidth-1:0] num_ff;
   logic [rpbu_pkg::DivWidth:0] est_sum;
   logic [rpbu_pkg::QuotWidth-1:0] quot_in;
   logic [rpbu_pkg::QuotWidth-1:0] quot_ff;

   logic [rpbu_pkg::DivWidth:0] rem;
   logic [rpbu_pkg::QuotWidth-1:0] quot_fix;
   logic [7:0] result_in;
   logic [7:0] result_ff;

   assign prod_in = $signed(op_ff.opx) * $signed(op_ff.opy);

   assign num_in = prod_ff[rpbu_pkg::DivWidth-1:0] + 17'd127;
   assign est_sum = {1'b0, num_in} + {9'd0, num_in[rpbu_pkg::DivWidth-1:8]};
   assign quot_in = est_sum[rpbu_pkg::QuotWidth+7:8];

   always_comb begin
      if (kind2_ff == rpbu_pkg::KIND_CLAMP) begin
         if (prod_ff[rpbu_pkg::ProductWidth-1]) begin
            value3_in = 8'd0;
         end else if (prod_ff[rpbu_pkg::ProductWidth-2:8] != '0) begin
            value3_in = 8'hFF;
         end else begin
            value3_in = prod_ff[7:0];
         end
      end else begin
         value3_in = value2_ff;
      end
   end

   assign rem = {1'b0, num_ff} - {1'b0, quot_ff, 8'd0} + {9'd0, quot_ff};
   assign quot_fix = (rem >= 18'd255) ? (quot_ff + 9'd1) : quot_ff;

   always_comb begin
      case (kind3_ff)
         rpbu_pkg::KIND_DIV: result_in = quot_fix[7:0];
         rpbu_pkg::KIND_INV: result_in = 8'hFF - quot_fix[7:0];
         default: result_in = value3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         op_ff <= op;
      end
      if (en.s2) begin
         kind2_ff <= op_ff.kind;
         value2_ff <= op_ff.value;
         prod_ff <= prod_in;
      end
      if (en.s3) begin
         kind3_ff <= kind2_ff;
         value3_ff <= value3_in;
         num_ff <= num_in;
         quot_ff <= quot_in;
      end
      if (en.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
